// File: sv/tevq_pkg.sv
`timescale 1ns / 1ps
// tevq_pkg: shared constants, item types and cell types for the timed event queue
// depends on nothing; used by tevq_cell and timed_event_queue

package tevq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TYPE_COUNT  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int TIME_W = 64;
    localparam int KIND_W = 4;
    localparam int ARG_W  = 32;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_CHANGE  = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KIND_W-1:0] event_type;
        logic [ARG_W-1:0]  delay;
        logic [ARG_W-1:0]  elapsed;
    } in_item_t;

    typedef struct packed {
        logic              fired;
        logic [KIND_W-1:0] fired_type;
        logic              preempt;
        logic              overflow;
        logic [TIME_W-1:0] current_time;
        logic              last;
    } out_item_t;

    // one queue slot as held by a cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // broadcast command to every cell
    typedef struct packed {
        logic              insert;
        logic              delete;
        logic [TIME_W-1:0] stamp;
        logic [KIND_W-1:0] kind;
    } cell_ctl_t;

endpackage

// File: sv/tevq_cell.sv
`timescale 1ns / 1ps
// tevq_cell: one slot of the sorted queue, shifts toward either neighbor
// depends on tevq_pkg

module tevq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tevq_pkg::cell_ctl_t ctl,
    input  tevq_pkg::entry_t   left,
    input  tevq_pkg::entry_t   right,
    input  logic               left_ge,
    input  logic               left_hit,
    output tevq_pkg::entry_t   q,
    output logic               ge,
    output logic               hit
);
    import tevq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] stamp_reg, stamp_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic              match;

    assign q     = '{valid: valid_reg, stamp: stamp_reg, kind: kind_reg};
    // new stamp goes at or before this slot
    assign ge    = !valid_reg || (ctl.stamp < stamp_reg);
    assign match = valid_reg && (kind_reg == ctl.kind);
    // first match seen at or before this slot
    assign hit   = left_hit || match;

    always_comb
    begin
        valid_next = valid_reg;
        stamp_next = stamp_reg;
        kind_next  = kind_reg;
        if (ctl.insert && ge)
        begin
            if (left_ge)
            begin
                valid_next = left.valid;
                stamp_next = left.stamp;
                kind_next  = left.kind;
            end
            else
            begin
                valid_next = 1'b1;
                stamp_next = ctl.stamp;
                kind_next  = ctl.kind;
            end
        end
        else if (ctl.delete && hit)
        begin
            valid_next = right.valid;
            stamp_next = right.stamp;
            kind_next  = right.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        kind_reg  <= kind_next;
    end

endmodule

// File: sv/timed_event_queue.sv
`timescale 1ns / 1ps
// timed_event_queue: global time clock and a time-sorted event queue built from a row of cells
// depends on tevq_pkg and tevq_cell
//
// usage
//   in channel: in_valid / in_stall / in_item carry one command item (add, remove,
//   change time, advance time). an item is taken when in_valid is high and in_stall low.
//   out channel: out_valid / out_stall / out_item carry result items; last marks the
//   final result of a command. advance may produce up to MAX_RESULTS fired items.
//   one command is handled at a time; in_stall is high while a command is in flight,
//   but a finished result may still wait in the output register while the next
//   command is accepted.
//   steps from accept to the result on the output register: add takes an insert step,
//   remove a remove step, change time a remove step and, if the type was found, an
//   insert step; advance takes a check step and then one fire step per fired item; an
//   add, remove or change with an out-of-range type goes straight to an emit step.
//   the sequencer steps the cell row with one insert or delete pass over all cells per
//   cycle while the output register is free.
//   reset clears the clock, all cell valid bits and the output valid bit; no sweep.
//   when the receiver stalls, the sequencer holds in its current step until the
//   output register is free, so no result is lost or repeated.

module timed_event_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tevq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output tevq_pkg::out_item_t out_item
);
    import tevq_pkg::*;

    localparam int CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REMOVE = 6'b000010,
        ST_INSERT = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_FIRE   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] clock_reg, clock_next;
    op_t               op_reg, op_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TIME_W-1:0] ins_time_reg, ins_time_next;
    logic [TIME_W-1:0] fire_time_reg, fire_time_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    // cell row
    cell_ctl_t ctl;
    entry_t    cell_q   [QUEUE_DEPTH];
    logic      cell_ge  [QUEUE_DEPTH];
    logic      cell_hit [QUEUE_DEPTH];
    logic      pop;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e, right_e;
            logic   left_ge_b, left_hit_b;
            if (gi == 0)
            begin : g_head
                assign left_e     = '0;
                assign left_ge_b  = 1'b0;
                // popping the head acts as a hit ahead of the first cell
                assign left_hit_b = pop;
            end
            else
            begin : g_body
                assign left_e     = cell_q[gi-1];
                assign left_ge_b  = cell_ge[gi-1];
                assign left_hit_b = cell_hit[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cell_q[gi+1];
            end
            tevq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .left     (left_e),
                .right    (right_e),
                .left_ge  (left_ge_b),
                .left_hit (left_hit_b),
                .q        (cell_q[gi]),
                .ge       (cell_ge[gi]),
                .hit      (cell_hit[gi])
            );
        end
    endgenerate

    logic in_accept, out_free, full, found, type_ok, head_due, next_tie, fire_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = cell_q[QUEUE_DEPTH-1].valid;
    assign found     = cell_hit[QUEUE_DEPTH-1];
    assign type_ok   = (32'(in_item.event_type) < TYPE_COUNT);
    assign head_due  = cell_q[0].valid && (cell_q[0].stamp <= clock_reg);
    assign next_tie  = cell_q[1].valid && (cell_q[1].stamp == fire_time_reg);
    assign fire_last = !next_tie || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    assign pop        = (state_reg == ST_FIRE);
    assign ctl.stamp  = ins_time_reg;
    assign ctl.kind   = kind_reg;
    assign ctl.insert = (state_reg == ST_INSERT) && out_free && !full;
    assign ctl.delete = ((state_reg == ST_REMOVE) || (state_reg == ST_FIRE)) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        ins_time_next  = ins_time_reg;
        fire_time_next = fire_time_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = op_t'(in_item.operation);
                    kind_next     = in_item.event_type;
                    // new event time: clock + elapsed + delay, wrapping
                    ins_time_next = clock_reg + TIME_W'(in_item.elapsed)
                                    + TIME_W'(in_item.delay);
                    if (op_t'(in_item.operation) != OP_REMOVE)
                    begin
                        clock_next = clock_reg + TIME_W'(in_item.elapsed);
                    end
                    unique case (op_t'(in_item.operation))
                        OP_ADD:              state_next = type_ok ? ST_INSERT : ST_EMIT;
                        OP_REMOVE, OP_CHANGE: state_next = type_ok ? ST_REMOVE : ST_EMIT;
                        OP_ADVANCE:          state_next = ST_CHECK;
                        default:             state_next = ST_EMIT;
                    endcase
                end
            end
            ST_REMOVE:
            begin
                if (out_free)
                begin
                    if (found && (op_reg == OP_CHANGE))
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = '{fired: 1'b0, fired_type: '0,
                                          preempt: (op_reg == OP_REMOVE) && cell_hit[0],
                                          overflow: 1'b0, current_time: clock_reg,
                                          last: 1'b1};
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{fired: 1'b0, fired_type: '0,
                                      preempt: !full && cell_ge[0],
                                      overflow: full, current_time: clock_reg,
                                      last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (head_due)
                begin
                    // late head pulls the clock back to its own time
                    fire_time_next = cell_q[0].stamp;
                    clock_next     = cell_q[0].stamp;
                    cnt_next       = '0;
                    state_next     = ST_FIRE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{fired: 1'b0, fired_type: '0, preempt: 1'b0,
                                      overflow: 1'b0, current_time: clock_reg,
                                      last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{fired: 1'b1, fired_type: cell_q[0].kind,
                                      preempt: 1'b0, overflow: 1'b0,
                                      current_time: clock_reg, last: fire_last};
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (fire_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{fired: 1'b0, fired_type: '0, preempt: 1'b0,
                                      overflow: 1'b0, current_time: clock_reg,
                                      last: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        kind_reg      <= kind_next;
        ins_time_reg  <= ins_time_next;
        fire_time_reg <= fire_time_next;
        cnt_reg       <= cnt_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
